[rtl/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define HCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define HCBD_NEVER(lbl, cond, msg) \
  `HCBD_ASSERT(lbl, !(cond), msg)

`endif

[rtl/hcbd_pkg.sv]
package hcbd_pkg;

  // default chunk size width
  localparam int SIZE_BITS_DEF = 24;

  // size line characters looked at for digits
  localparam logic [3:0] LINE_LIMIT = 4'd10;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // characters
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;

  // input request
  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_item_t;

  // result request
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
  } out_item_t;

  // result handed from the decoder core to the output buffer
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } hcbd_res_t;

  // decoded hex character
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      h.val = c[3:0];
    end else if ((c >= CHAR_LC_A && c <= CHAR_LC_F) || (c >= CHAR_UC_A && c <= CHAR_UC_F)) begin
      // low nibble of 'a'/'A' is 1, so add 9 to get 10
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

[rtl/hcbd_stream_if.sv]
// valid/ready channel carrying one request per handshake
interface hcbd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/http_chunked_body_decoder.sv]
// http chunked body decoder
//
// in_ch takes one body byte per request together with a restart flag; a set
// restart drops all decoder state and makes that byte the first of a new body.
// out_ch gives at most one result per input byte: a payload byte (kind data),
// a body complete marker (kind done) or a chunk size overflow (kind error).
// size line bytes, the two bytes after each chunk and bytes after an overflow
// give no result; after overflow the block waits for a restart.
//
// a byte is decoded in the cycle it is accepted and its result is registered in
// the output buffer, so the block takes one byte per cycle while in_ch.ready is
// high. the decoder core updates its state once per accepted byte and feeds a
// two-entry output buffer.
// when the receiver stalls, the buffer holds up to two results; in_ch.ready
// drops only while both entries are full.
// reset (synchronous, active low) puts the decoder at the start of a size line
// and empties the output buffer.
`include "assert_macros.svh"

module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  hcbd_stream_if.sink      in_ch,
  hcbd_stream_if.source    out_ch
);

  hcbd_res_t  res;
  logic       acc;
  logic       pop;
  logic [1:0] count_r, count_nxt;
  out_item_t  buf0_r, buf0_nxt;
  out_item_t  buf1_r, buf1_nxt;

  assign in_ch.ready  = (count_r != 2'd2);
  assign acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (count_r != 2'd0);
  assign out_ch.data  = buf0_r;
  assign pop          = out_ch.valid && out_ch.ready;

  hcbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (acc),
    .item (in_ch.data),
    .res  (res)
  );

  // two-entry output buffer, entry 0 drives the channel
  always_comb begin
    count_nxt = count_r;
    buf0_nxt  = buf0_r;
    buf1_nxt  = buf1_r;
    case ({res.valid, pop})
      2'b10: begin
        if (count_r == 2'd0) buf0_nxt = res.item;
        else                 buf1_nxt = res.item;
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        buf0_nxt  = buf1_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) buf0_nxt = res.item;
        else begin
          buf0_nxt = buf1_r;
          buf1_nxt = res.item;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
    buf0_r <= buf0_nxt;
    buf1_r <= buf1_nxt;
  end

  `HCBD_NEVER(a_count_range, count_r == 2'd3, "output buffer count out of range")
  `HCBD_ASSERT(a_nodata_zero,
    (out_ch.valid && out_ch.data.kind != KIND_DATA) |->
      (out_ch.data.out_byte == 8'd0 &&
       (out_ch.data.kind == KIND_DONE || out_ch.data.kind == KIND_ERROR)),
    "bad status result")
  `HCBD_ASSERT(a_out_hold,
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)),
    "result changed while stalled")

endmodule

[rtl/hcbd_core.sv]
`include "assert_macros.svh"

module hcbd_core
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      acc,
  input  in_item_t  item,
  output hcbd_res_t res
);

  typedef enum logic [2:0] {
    PH_SIZE,
    PH_DATA,
    PH_SKIP_DATA,
    PH_SKIP_ZERO,
    PH_DONE,
    PH_ERROR
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] accum_r, accum_nxt;
  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  logic [3:0]           lc_r, lc_nxt;
  logic                 stop_r, stop_nxt;
  logic                 cr_r, cr_nxt;
  logic [1:0]           sk_r, sk_nxt;

  phase_t               ph;
  hex_t                 hx;

  // one byte step of the decoder
  always_comb begin
    ph        = phase_r;
    accum_nxt = accum_r;
    rem_nxt   = rem_r;
    lc_nxt    = lc_r;
    stop_nxt  = stop_r;
    cr_nxt    = cr_r;
    sk_nxt    = sk_r;
    hx        = hex_digit(item.in_byte);
    res       = '0;

    // restart, or a byte after completion, opens a new body
    if (item.restart || phase_r == PH_DONE) begin
      ph        = PH_SIZE;
      accum_nxt = '0;
      rem_nxt   = '0;
      lc_nxt    = '0;
      stop_nxt  = 1'b0;
      cr_nxt    = 1'b0;
      sk_nxt    = '0;
    end
    phase_nxt = ph;

    unique case (ph)
      PH_SIZE: begin
        if (cr_nxt && item.in_byte == CHAR_LF) begin
          // end of size line
          if (accum_nxt == '0) begin
            phase_nxt = PH_SKIP_ZERO;
            sk_nxt    = 2'd2;
          end else begin
            phase_nxt = PH_DATA;
            rem_nxt   = accum_nxt;
          end
          accum_nxt = '0;
          lc_nxt    = '0;
          stop_nxt  = 1'b0;
          cr_nxt    = 1'b0;
        end else begin
          if (lc_nxt < LINE_LIMIT && !stop_nxt) begin
            if (!hx.ok) begin
              stop_nxt = 1'b1;
            end else if (accum_nxt[SIZE_BITS-1 -: 4] != 4'd0) begin
              // next digit would push the size past its width
              phase_nxt      = PH_ERROR;
              res.valid      = acc;
              res.item.kind  = KIND_ERROR;
            end else begin
              accum_nxt = {accum_nxt[SIZE_BITS-5:0], hx.val};
            end
          end
          if (lc_nxt < LINE_LIMIT) lc_nxt = lc_nxt + 4'd1;
          cr_nxt = (item.in_byte == CHAR_CR);
        end
      end
      PH_DATA: begin
        rem_nxt           = rem_nxt - SIZE_BITS'(1'b1);
        res.valid         = acc;
        res.item.kind     = KIND_DATA;
        res.item.out_byte = item.in_byte;
        if (rem_nxt == '0) begin
          phase_nxt = PH_SKIP_DATA;
          sk_nxt    = 2'd2;
        end
      end
      PH_SKIP_DATA: begin
        if (sk_nxt != 2'd0) sk_nxt = sk_nxt - 2'd1;
        if (sk_nxt == 2'd0) begin
          phase_nxt = PH_SIZE;
          accum_nxt = '0;
          lc_nxt    = '0;
          stop_nxt  = 1'b0;
          cr_nxt    = 1'b0;
        end
      end
      PH_SKIP_ZERO: begin
        if (sk_nxt != 2'd0) sk_nxt = sk_nxt - 2'd1;
        if (sk_nxt == 2'd0) begin
          phase_nxt     = PH_DONE;
          res.valid     = acc;
          res.item.kind = KIND_DONE;
        end
      end
      PH_ERROR: begin
        phase_nxt = PH_ERROR;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
  end

  // decoder state, advanced once per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      accum_r <= '0;
      rem_r   <= '0;
      lc_r    <= '0;
      stop_r  <= 1'b0;
      cr_r    <= 1'b0;
      sk_r    <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      rem_r   <= rem_nxt;
      lc_r    <= lc_nxt;
      stop_r  <= stop_nxt;
      cr_r    <= cr_nxt;
      sk_r    <= sk_nxt;
    end
  end

  `HCBD_NEVER(a_error_silent,
    acc && phase_r == PH_ERROR && !item.restart && res.valid,
    "result while in error")
  `HCBD_ASSERT(a_done_next,
    (res.valid && res.item.kind == KIND_DONE) |=> phase_r == PH_DONE,
    "completion without done phase")
  `HCBD_ASSERT(a_error_next,
    (res.valid && res.item.kind == KIND_ERROR) |=> phase_r == PH_ERROR,
    "overflow without error phase")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
  import hcbd_pkg::*;
();

  localparam int SIZE_BITS = SIZE_BITS_DEF;
  localparam int N_ITEMS = 1250;
  localparam int END_DRAIN_CYCLES = 20;
  localparam int RX_HOLD_LEN = 300;

  localparam logic [7:0] CHAR_SEMI  = ";";
  localparam logic [7:0] CHAR_SPACE = " ";

  // decoder position within the body
  typedef enum logic [2:0] {
    PH_SIZE_LINE,
    PH_DATA,
    PH_SKIP_DATA,
    PH_SKIP_ZERO,
    PH_DONE,
    PH_OVERFLOW
  } chunk_phase_t;

  // chunk decoder prediction and result matching
  class chunk_scoreboard;
    chunk_phase_t         phase;
    logic [SIZE_BITS+3:0] size_sum;
    logic [SIZE_BITS-1:0] bytes_left;
    logic [3:0]           line_len;
    bit                   digits_done;
    bit                   last_cr;
    int unsigned          skip_cnt;
    out_item_t            expected_q[$];
    int unsigned          error_cnt;

    function new();
      error_cnt = 0;
      clear_body();
    endfunction

    function void clear_line();
      size_sum    = '0;
      line_len    = '0;
      digits_done = 1'b0;
      last_cr     = 1'b0;
    endfunction

    function void clear_body();
      phase      = PH_SIZE_LINE;
      bytes_left = '0;
      skip_cnt   = 0;
      clear_line();
    endfunction

    function bit ignoring();
      return phase == PH_OVERFLOW;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push_result(logic [7:0] b, logic [1:0] k);
      out_item_t r;
      r.out_byte = b;
      r.kind     = k;
      expected_q.push_back(r);
    endfunction

    // digit value of a size line character, -1 when not hex
    function int digit_of(logic [7:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
      if (c >= CHAR_LC_A && c <= CHAR_LC_F) return int'(c - CHAR_LC_A) + 10;
      if (c >= CHAR_UC_A && c <= CHAR_UC_F) return int'(c - CHAR_UC_A) + 10;
      return -1;
    endfunction

    // advance the decoder by one accepted request
    function void note_request(in_item_t req);
      int dig;
      logic [SIZE_BITS+3:0] sz;
      if (req.restart || phase == PH_DONE) clear_body();
      case (phase)
        PH_SIZE_LINE: begin
          if (last_cr && req.in_byte == CHAR_LF) begin
            sz = size_sum;
            clear_line();
            if (sz == 0) begin
              phase    = PH_SKIP_ZERO;
              skip_cnt = 2;
            end else begin
              phase      = PH_DATA;
              bytes_left = sz[SIZE_BITS-1:0];
            end
            return;
          end
          if (line_len < LINE_LIMIT && !digits_done) begin
            dig = digit_of(req.in_byte);
            if (dig < 0) begin
              digits_done = 1'b1;
            end else begin
              size_sum = (size_sum << 4) | (SIZE_BITS + 4)'(dig);
              if (size_sum[SIZE_BITS+3:SIZE_BITS] != 0) begin
                phase = PH_OVERFLOW;
                push_result(8'h00, KIND_ERROR);
                return;
              end
            end
          end
          if (line_len < LINE_LIMIT) line_len++;
          last_cr = (req.in_byte == CHAR_CR);
        end
        PH_DATA: begin
          bytes_left--;
          if (bytes_left == 0) begin
            phase    = PH_SKIP_DATA;
            skip_cnt = 2;
          end
          push_result(req.in_byte, KIND_DATA);
        end
        PH_SKIP_DATA: begin
          if (skip_cnt > 0) skip_cnt--;
          if (skip_cnt == 0) begin
            phase = PH_SIZE_LINE;
            clear_line();
          end
        end
        PH_SKIP_ZERO: begin
          if (skip_cnt > 0) skip_cnt--;
          if (skip_cnt == 0) begin
            phase = PH_DONE;
            push_result(8'h00, KIND_DONE);
          end
        end
        default: begin
          phase = PH_OVERFLOW;
        end
      endcase
    endfunction

    // compare one delivered result with the oldest prediction
    function void check_result(out_item_t res);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual out_byte %0h kind %0d",
                 $time, res.out_byte, res.kind);
        error_cnt++;
        return;
      end
      want = expected_q.pop_front();
      if (res.out_byte !== want.out_byte) begin
        $display("%0t: out_byte mismatch, expected %0h, actual %0h",
                 $time, want.out_byte, res.out_byte);
        error_cnt++;
      end
      if (res.kind !== want.kind) begin
        $display("%0t: kind mismatch, expected %0d, actual %0d", $time, want.kind, res.kind);
        error_cnt++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;
  int useful_cnt;
  bit restart_next;
  bit spont_restart;

  chunk_scoreboard sb = new();

  hcbd_stream_if #(.payload_t(in_item_t))  in_ch ();
  hcbd_stream_if #(.payload_t(out_item_t)) out_ch ();

  http_chunked_body_decoder #(
    .SIZE_BITS(SIZE_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // offer one byte and wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    in_item_t req;
    req.in_byte  = b;
    req.restart  = restart_next || (spont_restart && $urandom_range(199) == 0);
    restart_next = 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_crlf();
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  // hex character for a nibble, letters in either case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return CHAR_0 + 8'(nib);
    return ($urandom_range(1) ? CHAR_UC_A : CHAR_LC_A) + 8'(nib) - 8'd10;
  endfunction

  // size line with optional leading zeros and extension
  task automatic send_size_line(input logic [SIZE_BITS-1:0] val);
    int ndig;
    int lead;
    ndig = 1;
    while (ndig < SIZE_BITS / 4 && (val >> (4 * ndig)) != 0) ndig++;
    lead = ($urandom_range(7) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 1);
    // empty line for a zero size now and then
    if (val == 0 && $urandom_range(3) == 0) begin
      ndig = 0;
      lead = 0;
    end
    repeat (lead) send_byte(CHAR_0);
    for (int i = ndig - 1; i >= 0; i--) send_byte(hex_char(val[4*i +: 4]));
    case ($urandom_range(7))
      0: begin
        send_byte(CHAR_SEMI);
        repeat ($urandom_range(1, 8)) send_byte(CHAR_LC_A + 8'($urandom_range(25)));
      end
      1: send_byte(CHAR_SPACE);
      2: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
      default: ;
    endcase
    send_crlf();
  endtask

  // two bytes after a chunk, usually crlf
  task automatic send_trailer();
    if ($urandom_range(4) == 0) begin
      send_byte(8'($urandom_range(255)));
      send_byte(8'($urandom_range(255)));
    end else begin
      send_crlf();
    end
  endtask

  // complete body: up to three chunks and the closing zero chunk
  task automatic send_body();
    int unsigned n_chunks;
    int unsigned len;
    n_chunks = $urandom_range(0, 3);
    repeat (n_chunks) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 8);
      send_size_line(SIZE_BITS'(len));
      repeat (len) send_byte(8'($urandom_range(255)));
      send_trailer();
    end
    send_size_line('0);
    send_trailer();
  endtask

  // size that no longer fits, then ignored bytes and a restart
  task automatic send_oversize();
    send_byte(hex_char(4'($urandom_range(1, 15))));
    repeat ($urandom_range(6, 8)) send_byte(hex_char(4'($urandom_range(15))));
    repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(255)));
    restart_next = 1'b1;
  endtask

  // accepted requests feed the prediction
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (!sb.ignoring()) useful_cnt++;
      sb.note_request(in_ch.data);
    end
  end

  // delivered results are checked in order
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // receiver with random stalls and one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // stimulus and end of run
  initial begin
    int base;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.data     <= '0;
    tx_idle_pct    = 6;
    rx_idle_pct    = 56;
    rx_hold_cycles = 0;
    useful_cnt     = 0;
    restart_next   = 1'b0;
    spont_restart  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // empty size line ends the body at once
    send_crlf();
    send_crlf();
    // non-hex ends the digit sum, payload extremes, skipped bytes of any value
    send_byte("2");
    send_byte("g");
    send_crlf();
    send_byte(8'h00);
    send_byte(8'hff);
    send_crlf();
    send_byte(CHAR_0);
    send_crlf();
    send_byte(8'hff);
    send_byte(8'h00);
    // mixed case digits that overflow the size, then ignored bytes
    send_byte(CHAR_LC_F);
    repeat (6) send_byte(CHAR_UC_F);
    send_crlf();
    restart_next = 1'b1;

    // random bodies in three idle settings
    spont_restart = 1'b1;
    base = useful_cnt;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 56 : 0;
      rx_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 6 : 0;
      if (ph == 2) rx_hold_cycles = RX_HOLD_LEN;
      while (useful_cnt < base + N_ITEMS * (ph + 1) / 3) begin
        if (sb.ignoring() || $urandom_range(15) == 0) restart_next = 1'b1;
        case ($urandom_range(9))
          0: send_oversize();
          1: begin
            // loose noise bytes
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
            restart_next = 1'b1;
          end
          2: begin
            // very large chunk cut short by a restart
            send_size_line(SIZE_BITS'($urandom_range(256, (1 << SIZE_BITS) - 1)));
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
            restart_next = 1'b1;
          end
          default: send_body();
        endcase
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (END_DRAIN_CYCLES) @(posedge clk);
    if (sb.error_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
